// ===== rtl/core/cesd_pkg.sv =====
// shared types, character codes and the escape table of the caret/backslash decoder
// no dependencies; imported by every module of the core
package cesd_pkg;

  localparam int MAX_OUT_DEFAULT     = 32;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [1:0] {
    MODE_NORMAL    = 2'd0,
    MODE_CARET     = 2'd1,
    MODE_BACKSLASH = 2'd2,
    MODE_OCTAL     = 2'd3
  } mode_t;

  // one result word
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       eos;
  } res_t;

  // everything one input word produces: one or two result words
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } bundle_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } esc_t;

  // named escapes after a backslash
  function automatic esc_t esc_map(input logic [7:0] c);
    esc_t r;
    r.hit  = 1'b1;
    r.code = 8'd0;
    case (c)
      8'h61:     r.code = 8'd7;   // a
      8'h62:     r.code = 8'd8;   // b
      8'h65:     r.code = 8'd27;  // e
      8'h66:     r.code = 8'd12;  // f
      8'h6E:     r.code = 8'd10;  // n
      8'h72:     r.code = 8'd13;  // r
      8'h74:     r.code = 8'd9;   // t
      8'h76:     r.code = 8'd11;  // v
      CH_BSLASH: r.code = CH_BSLASH;
      CH_CARET:  r.code = CH_CARET;
      CH_HASH:   r.code = CH_HASH;
      default:   r.hit  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/cesd_front.sv =====
// front end: takes input words, tracks escape state and forms the result bundle
// depends on cesd_pkg
module cesd_front #(
  parameter int MaxOut = cesd_pkg::MAX_OUT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic              is_last,
  output logic              wr,
  output cesd_pkg::bundle_t wr_bundle
);
  import cesd_pkg::*;

  localparam int CntW = $clog2(MaxOut + 1);
  localparam logic [CntW:0] MaxOutW = (CntW + 1)'(MaxOut);

  mode_t           mode, mode_next;
  logic [7:0]      oval, oval_next;
  logic [1:0]      digits, digits_next;
  logic [CntW-1:0] emitted, emitted_next;

  logic [1:0] att_n;
  logic [7:0] att0, att1;
  logic [7:0] oct_sum;
  logic       is_digit;
  logic       has1, has2;
  logic [1:0] keep;
  esc_t       esc;

  assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign oct_sum  = {oval[4:0], 3'b000} + {4'b0000, in_byte[3:0]};
  assign esc      = esc_map(in_byte);

  // escape decode, up to two bytes attempted per word
  always_comb begin
    att_n       = 2'd0;
    att0        = 8'd0;
    att1        = 8'd0;
    mode_next   = mode;
    oval_next   = oval;
    digits_next = digits;
    unique case (mode)
      MODE_NORMAL: begin
        if (in_byte == CH_CARET) begin
          mode_next = MODE_CARET;
        end else if (in_byte == CH_BSLASH) begin
          mode_next = MODE_BACKSLASH;
        end else begin
          att0  = in_byte;
          att_n = 2'd1;
        end
      end
      MODE_CARET: begin
        mode_next = MODE_NORMAL;
        if (in_byte inside {[8'h41:8'h5F], [8'h61:8'h7A]}) begin
          att0  = {3'b000, in_byte[4:0]};
          att_n = 2'd1;
        end else if (in_byte == CH_SPACE || in_byte == CH_AT) begin
          att0  = 8'd0;
          att_n = 2'd1;
        end else begin
          att0  = CH_CARET;
          att1  = in_byte;
          att_n = 2'd2;
        end
      end
      MODE_BACKSLASH: begin
        mode_next = MODE_NORMAL;
        if (esc.hit) begin
          att0  = esc.code;
          att_n = 2'd1;
        end else if (is_digit) begin
          oval_next   = {4'b0000, in_byte[3:0]};
          digits_next = 2'd1;
          mode_next   = MODE_OCTAL;
        end else begin
          att0  = CH_BSLASH;
          att1  = in_byte;
          att_n = 2'd2;
        end
      end
      MODE_OCTAL: begin
        if (is_digit) begin
          digits_next = digits + 2'd1;
          if (digits_next == 2'd3 || digits_next == 2'd0) begin
            att0        = oct_sum;
            att_n       = 2'd1;
            mode_next   = MODE_NORMAL;
            oval_next   = 8'd0;
            digits_next = 2'd0;
          end else begin
            oval_next = oct_sum;
          end
        end else begin
          // run ends: value first, then the byte in normal mode
          att0        = oval;
          att_n       = 2'd1;
          mode_next   = MODE_NORMAL;
          oval_next   = 8'd0;
          digits_next = 2'd0;
          if (in_byte == CH_CARET) begin
            mode_next = MODE_CARET;
          end else if (in_byte == CH_BSLASH) begin
            mode_next = MODE_BACKSLASH;
          end else begin
            att1  = in_byte;
            att_n = 2'd2;
          end
        end
      end
      default: ;
    endcase

    // flush a pending prefix or digit run at end of string
    if (is_last && mode_next != MODE_NORMAL) begin
      if (att_n == 2'd0) begin
        att0 = (mode_next == MODE_CARET) ? CH_CARET :
               (mode_next == MODE_BACKSLASH) ? CH_BSLASH : oval_next;
      end else begin
        att1 = (mode_next == MODE_CARET) ? CH_CARET :
               (mode_next == MODE_BACKSLASH) ? CH_BSLASH : oval_next;
      end
      att_n = att_n + 2'd1;
    end
  end

  // output limit per string
  assign has1 = {1'b0, emitted} < MaxOutW;
  assign has2 = ({1'b0, emitted} + {{CntW{1'b0}}, 1'b1}) < MaxOutW;

  always_comb begin
    keep = 2'd0;
    case (att_n)
      2'd1:    keep = has1 ? 2'd1 : 2'd0;
      2'd2:    keep = has2 ? 2'd2 : (has1 ? 2'd1 : 2'd0);
      default: keep = 2'd0;
    endcase
  end

  always_comb begin
    wr_bundle.two      = (keep == 2'd2);
    wr_bundle.r0.data  = (keep == 2'd0) ? 8'd0 : att0;
    wr_bundle.r0.valid = (keep != 2'd0);
    wr_bundle.r0.eos   = is_last && (keep != 2'd2);
    wr_bundle.r1.data  = att1;
    wr_bundle.r1.valid = 1'b1;
    wr_bundle.r1.eos   = is_last;
  end

  assign wr = accept && ((keep != 2'd0) || is_last);

  assign emitted_next = is_last ? '0 : emitted + CntW'(keep);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_NORMAL;
      oval    <= 8'd0;
      digits  <= 2'd0;
      emitted <= '0;
    end else if (accept) begin
      mode    <= is_last ? MODE_NORMAL : mode_next;
      oval    <= is_last ? 8'd0 : oval_next;
      digits  <= is_last ? 2'd0 : digits_next;
      emitted <= emitted_next;
    end
  end

  a_cap: assert property (@(posedge clk) disable iff (rst)
    {1'b0, emitted} <= MaxOutW)
    else $error("emitted count past limit");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && is_last |=> mode == MODE_NORMAL && emitted == '0 && digits == 2'd0)
    else $error("state not cleared after end of string");

endmodule

// ===== rtl/core/cesd_queue.sv =====
// short queue of result bundles between front and back
// depends on cesd_pkg
module cesd_queue #(
  parameter int Depth = cesd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  cesd_pkg::bundle_t wr_bundle,
  input  logic              rd,
  output cesd_pkg::bundle_t head,
  output logic              full,
  output logic              q_empty
);
  import cesd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  bundle_t         mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign head    = mem[rd_ptr];
  assign full    = (count == CntW'(Depth));
  assign q_empty = (count == '0);

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (rd) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (wr && !rd) begin
        count <= count + CntW'(1);
      end else if (rd && !wr) begin
        count <= count - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr |-> !full)
    else $error("write into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd |-> !q_empty)
    else $error("read from empty queue");

endmodule

// ===== rtl/core/cesd_back.sv =====
// back end: splits each bundle into result words and holds one in the output register
// depends on cesd_pkg
module cesd_back (
  input  logic              clk,
  input  logic              rst,
  input  cesd_pkg::bundle_t head,
  input  logic              q_empty,
  output logic              rd,
  input  logic              pop,
  output logic              empty,
  output logic [7:0]        out_byte,
  output logic              byte_valid,
  output logic              end_of_string
);
  import cesd_pkg::*;

  res_t out_res;
  logic out_valid;
  logic sel;   // second word of the head bundle is next
  logic load;

  assign load = !out_valid || pop;
  assign rd   = load && !q_empty && (sel || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        sel <= !sel && head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      out_res <= sel ? head.r1 : head.r0;
    end
  end

  assign empty         = !out_valid;
  assign out_byte      = out_res.data;
  assign byte_valid    = out_res.valid;
  assign end_of_string = out_res.eos;

  a_sel_has_bundle: assert property (@(posedge clk) disable iff (rst)
    sel |-> !q_empty && head.two)
    else $error("second word pending without a two-word bundle");

endmodule

// ===== rtl/core/caret_escape_string_decoder_core.sv =====
// Caret and backslash escape decoder. One text byte per word goes in with a last-of-string
// flag; decoded raw bytes come out, one per word, with end_of_string on the last word of each
// string (a bare marker with byte_valid low when the MaxOut limit dropped the last word's
// bytes). A new input word is taken every cycle while full is low. The front decodes in the
// accept cycle and writes a bundle of one or two result words into a queue of QueueDepth
// bundles; while the output register is empty or popped, the back moves one result word per
// cycle from the queue into it. Two-byte inputs hold the back for both of their words, so a
// long run of them fills the queue and raises full. At most MaxOut bytes come out per string.
// Depends on cesd_pkg, cesd_front, cesd_queue and cesd_back.
module caret_escape_string_decoder_core #(
  parameter int MaxOut     = cesd_pkg::MAX_OUT_DEFAULT,
  parameter int QueueDepth = cesd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       is_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       end_of_string
);
  import cesd_pkg::*;

  logic    accept;
  logic    wr;
  logic    rd;
  logic    q_empty;
  bundle_t wr_bundle;
  bundle_t head;

  assign accept = push && !full;

  cesd_front #(
    .MaxOut(MaxOut)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (in_byte),
    .is_last  (is_last),
    .wr       (wr),
    .wr_bundle(wr_bundle)
  );

  cesd_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .wr_bundle(wr_bundle),
    .rd       (rd),
    .head     (head),
    .full     (full),
    .q_empty  (q_empty)
  );

  cesd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (q_empty),
    .rd           (rd),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .end_of_string(end_of_string)
  );

endmodule
